>>> rtl/pdisfe_pkg.sv
`default_nettype none
package pdisfe_pkg;

    localparam int STATE_DIM   = 2;
    localparam int BASIS_ORDER = 3;
    localparam int NUM_ACTIONS = 4;

    localparam int NUM_BASIS = (BASIS_ORDER + 1) ** STATE_DIM;
    localparam int WORDS     = 64;
    localparam int WADDR_W   = 6;
    localparam int BASIS_W   = (NUM_BASIS > 1) ? $clog2(NUM_BASIS) : 1;
    localparam int ACT_W     = $clog2(NUM_ACTIONS);
    localparam int DIGIT_W   = $clog2(BASIS_ORDER + 1);

    localparam int PROD_W  = 49;
    localparam int ACC_W   = 64;
    localparam int Z_W     = ACC_W - 15;
    localparam int SUM_E_W = 20;
    localparam int DEN_W   = 37;
    localparam int NUM_W   = 53;
    localparam int DCNT_W  = $clog2(NUM_W + 1);

    function automatic logic [15:0] cos_tab(input logic [4:0] i);
        logic [15:0] v;
        unique case (i)
            5'd0:  v = 16'd32768;
            5'd1:  v = 16'd32610;
            5'd2:  v = 16'd32138;
            5'd3:  v = 16'd31357;
            5'd4:  v = 16'd30274;
            5'd5:  v = 16'd28899;
            5'd6:  v = 16'd27246;
            5'd7:  v = 16'd25330;
            5'd8:  v = 16'd23170;
            5'd9:  v = 16'd20788;
            5'd10: v = 16'd18205;
            5'd11: v = 16'd15447;
            5'd12: v = 16'd12540;
            5'd13: v = 16'd9512;
            5'd14: v = 16'd6393;
            5'd15: v = 16'd3212;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    function automatic logic [16:0] exp_whole(input logic [3:0] n);
        logic [16:0] v;
        unique case (n)
            4'd0:  v = 17'd65536;
            4'd1:  v = 17'd24109;
            4'd2:  v = 17'd8869;
            4'd3:  v = 17'd3263;
            4'd4:  v = 17'd1200;
            4'd5:  v = 17'd442;
            4'd6:  v = 17'd162;
            4'd7:  v = 17'd60;
            4'd8:  v = 17'd22;
            4'd9:  v = 17'd8;
            4'd10: v = 17'd3;
            4'd11: v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic logic [16:0] exp_part(input logic [4:0] j);
        logic [16:0] v;
        unique case (j)
            5'd0:  v = 17'd65536;
            5'd1:  v = 17'd61565;
            5'd2:  v = 17'd57835;
            5'd3:  v = 17'd54331;
            5'd4:  v = 17'd51040;
            5'd5:  v = 17'd47947;
            5'd6:  v = 17'd45042;
            5'd7:  v = 17'd42313;
            5'd8:  v = 17'd39750;
            5'd9:  v = 17'd37341;
            5'd10: v = 17'd35079;
            5'd11: v = 17'd32954;
            5'd12: v = 17'd30957;
            5'd13: v = 17'd29081;
            5'd14: v = 17'd27319;
            5'd15: v = 17'd25664;
            default: v = 17'd24109;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] cos_quarter(input logic [14:0] x);
        logic [15:0] c0;
        logic [15:0] c1;
        logic [15:0] d;
        logic [25:0] p;
        c0 = cos_tab({1'b0, x[13:10]});
        c1 = cos_tab({1'b0, x[13:10]} + 5'd1);
        d  = c0 - c1;
        p  = 26'(d) * 26'(x[9:0]);
        if (x[14]) begin
            return 16'd0;
        end
        return c0 - p[25:10];
    endfunction

    function automatic logic signed [16:0] fourier_cos(input logic [15:0] p);
        logic [14:0] r;
        logic [14:0] nr;
        logic [15:0] v;
        logic        neg;
        r  = {1'b0, p[13:0]};
        nr = 15'd16384 - r;
        unique case (p[15:14])
            2'd0: begin v = cos_quarter(r);  neg = 1'b0; end
            2'd1: begin v = cos_quarter(nr); neg = 1'b1; end
            2'd2: begin v = cos_quarter(r);  neg = 1'b1; end
            default: begin v = cos_quarter(nr); neg = 1'b0; end
        endcase
        return neg ? -$signed({1'b0, v}) : $signed({1'b0, v});
    endfunction

    // {clipped, value} of a 48-bit saturating result
    function automatic logic [48:0] sat48(input logic signed [49:0] s);
        if (s > 50'sh0_7FFF_FFFF_FFFF) begin
            return {1'b1, 48'h7FFF_FFFF_FFFF};
        end
        if (s < -50'sh0_8000_0000_0000) begin
            return {1'b1, 48'h8000_0000_0000};
        end
        return {1'b0, s[47:0]};
    endfunction

endpackage
`default_nettype wire

>>> rtl/pdis_softmax_fourier_estimator.sv
`default_nettype none
// timestep work at the default sizes: phi table fill, 64-word weight walk, softmax terms
// and the divider; the divider is skipped when the behavior probability is zero
// one item at a time: a timestep is taken only when idle; weights 1 per cycle while idle
// result beat leaves through an output register, the next item is taken meanwhile
// synchronous active-low reset clears control and episode state (ratio to one)
// weight memories are not cleared by reset
module pdis_softmax_fourier_estimator (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic         s_kind,
    input  wire logic         s_weight_policy,
    input  wire logic [5:0]   s_weight_index,
    input  wire logic [31:0]  s_weight_value,
    input  wire logic [15:0]  s_feature_0,
    input  wire logic [15:0]  s_feature_1,
    input  wire logic [15:0]  s_feature_2,
    input  wire logic [15:0]  s_feature_3,
    input  wire logic [1:0]   s_action,
    input  wire logic [31:0]  s_reward,
    input  wire logic         s_last_step,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [47:0]       m_pdis_estimate,
    output logic [47:0]       m_return_sum,
    output logic              m_saturated
);
    import pdisfe_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PHI   = 4'd1;
    localparam logic [3:0] S_DOT   = 4'd2;
    localparam logic [3:0] S_EXP   = 4'd3;
    localparam logic [3:0] S_PREP  = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_RATIO = 4'd6;
    localparam logic [3:0] S_TERM  = 4'd7;
    localparam logic [3:0] S_ACC   = 4'd8;
    localparam logic [3:0] S_EMIT  = 4'd9;

    logic [3:0] state_reg;

    logic [15:0] feat_in [4];
    logic [15:0] feat_reg [STATE_DIM];
    logic [DIGIT_W-1:0] digit_reg [STATE_DIM];
    logic [ACT_W-1:0] act_reg;
    logic [ACT_W-1:0] act_in;
    logic signed [31:0] rew_reg;
    logic last_reg;

    logic [31:0] eval_mem [WORDS];
    logic [31:0] beh_mem [WORDS];
    logic signed [16:0] phi_mem [NUM_BASIS];
    logic [31:0] we_rd_reg, wb_rd_reg;
    logic signed [16:0] phi_rd_reg;

    logic [BASIS_W-1:0] basis_reg;
    logic [ACT_W-1:0] act_cnt_reg;
    logic [WADDR_W-1:0] waddr_reg;
    logic issue_reg;

    logic v1_reg, v2_reg, last1_reg, last2_reg;
    logic [ACT_W-1:0] a1_reg, a2_reg;
    logic signed [PROD_W-1:0] pe_reg, pb_reg;
    logic signed [ACC_W-1:0] acc_e_reg, acc_b_reg;
    logic signed [Z_W-1:0] ze_reg [NUM_ACTIONS];
    logic signed [Z_W-1:0] zb_reg [NUM_ACTIONS];
    logic signed [Z_W-1:0] zmax_e_reg, zmax_b_reg;

    logic [ACT_W-1:0] exp_cnt_reg;
    logic sub_reg;
    logic [16:0] ep_e_reg, ep_b_reg;
    logic [3:0] n_e_reg, n_b_reg;
    logic zero_e_reg, zero_b_reg;
    logic [SUM_E_W-1:0] se_reg, sb_reg;
    logic [16:0] ee_reg, eb_reg;

    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic [31:0] q_reg;

    logic [31:0] ratio_reg;
    logic [47:0] mag_reg;
    logic signed [47:0] pdis_reg, rsum_reg;
    logic clip_reg;

    logic m_valid_reg;
    logic [47:0] m_pdis_reg, m_rsum_reg;
    logic m_sat_reg;

    // combinational helpers
    logic [15:0] phase;
    logic signed [16:0] phi_val;
    logic signed [ACC_W-1:0] sum_e, sum_b;
    logic signed [Z_W-1:0] z_e, z_b;
    logic [16:0] epart_e, epart_b;
    logic zero_e, zero_b;
    logic [3:0] n_e, n_b;
    logic [16:0] ex_e, ex_b;
    logic [DEN_W:0] rem_s;
    logic [63:0] rprod;
    logic [63:0] mprod;
    logic [31:0] abs_rew;
    logic signed [48:0] term;
    logic [48:0] sat_p, sat_r;

    assign feat_in[0] = s_feature_0;
    assign feat_in[1] = s_feature_1;
    assign feat_in[2] = s_feature_2;
    assign feat_in[3] = s_feature_3;

    always_comb begin
        if (int'(s_action) >= NUM_ACTIONS) begin
            act_in = ACT_W'(NUM_ACTIONS - 1);
        end else begin
            act_in = ACT_W'(s_action);
        end
    end

    always_comb begin
        phase = 16'd0;
        for (int j = 0; j < STATE_DIM; j++) begin
            phase = phase + 16'(feat_reg[j] * 16'(digit_reg[j]));
        end
        phi_val = fourier_cos(phase);
    end

    always_comb begin
        sum_e = acc_e_reg + ACC_W'(pe_reg);
        sum_b = acc_b_reg + ACC_W'(pb_reg);
        z_e = Z_W'(sum_e >>> 15);
        z_b = Z_W'(sum_b >>> 15);
    end

    function automatic logic [21:0] exp_frac(input logic signed [Z_W:0] u);
        logic [16:0] p0, p1, d;
        logic [28:0] pr;
        logic big;
        p0  = exp_part({1'b0, u[15:12]});
        p1  = exp_part({1'b0, u[15:12]} + 5'd1);
        d   = p0 - p1;
        pr  = 29'(d) * 29'(u[11:0]);
        big = (u >= (Z_W+1)'(12 * 65536));
        return {big, u[19:16], 17'(p0 - pr[28:12])};
    endfunction

    always_comb begin
        logic signed [Z_W:0] ue, ub;
        logic [21:0] fe, fb;
        logic [33:0] xe, xb;
        ue = (Z_W+1)'(zmax_e_reg) - (Z_W+1)'(ze_reg[exp_cnt_reg]);
        ub = (Z_W+1)'(zmax_b_reg) - (Z_W+1)'(zb_reg[exp_cnt_reg]);
        fe = exp_frac(ue);
        fb = exp_frac(ub);
        zero_e = fe[21];
        zero_b = fb[21];
        n_e = fe[20:17];
        n_b = fb[20:17];
        epart_e = fe[16:0];
        epart_b = fb[16:0];
        xe = 34'(exp_whole(n_e_reg)) * 34'(ep_e_reg);
        xb = 34'(exp_whole(n_b_reg)) * 34'(ep_b_reg);
        ex_e = zero_e_reg ? 17'd0 : xe[32:16];
        ex_b = zero_b_reg ? 17'd0 : xb[32:16];
    end

    always_comb begin
        rem_s = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};
        rprod = 64'(ratio_reg) * 64'(q_reg);
        abs_rew = rew_reg[31] ? (32'd0 - rew_reg) : rew_reg;
        mprod = 64'(ratio_reg) * 64'(abs_rew);
        term = rew_reg[31] ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});
        sat_p = sat48(50'(pdis_reg) + 50'(term));
        sat_r = sat48(50'(rsum_reg) + 50'(rew_reg));
    end

    assign s_ready = (state_reg == S_IDLE);

    // weight and basis memories
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready && !s_kind) begin
            if (s_weight_policy) begin
                beh_mem[s_weight_index] <= s_weight_value;
            end else begin
                eval_mem[s_weight_index] <= s_weight_value;
            end
        end
        we_rd_reg <= eval_mem[waddr_reg];
        wb_rd_reg <= beh_mem[waddr_reg];
        if (state_reg == S_PHI) begin
            phi_mem[basis_reg] <= phi_val;
        end
        phi_rd_reg <= phi_mem[basis_reg];
    end

    // datapath registers without reset
    always_ff @(posedge aclk) begin
        pe_reg <= $signed(we_rd_reg) * phi_rd_reg;
        pb_reg <= $signed(wb_rd_reg) * phi_rd_reg;
        if (s_valid && s_ready && s_kind) begin
            for (int j = 0; j < STATE_DIM; j++) begin
                feat_reg[j] <= feat_in[j];
            end
            act_reg  <= act_in;
            rew_reg  <= s_reward;
            last_reg <= s_last_step;
        end
        if (v2_reg && last2_reg) begin
            ze_reg[a2_reg] <= z_e;
            zb_reg[a2_reg] <= z_b;
            if (a2_reg == '0 || z_e > zmax_e_reg) begin
                zmax_e_reg <= z_e;
            end
            if (a2_reg == '0 || z_b > zmax_b_reg) begin
                zmax_b_reg <= z_b;
            end
        end
        if (state_reg == S_EXP && !sub_reg) begin
            ep_e_reg   <= epart_e;
            ep_b_reg   <= epart_b;
            n_e_reg    <= n_e;
            n_b_reg    <= n_b;
            zero_e_reg <= zero_e;
            zero_b_reg <= zero_b;
        end
        if (state_reg == S_TERM) begin
            mag_reg <= mprod[63:16];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            issue_reg   <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            ratio_reg   <= 32'h0001_0000;
            pdis_reg    <= '0;
            rsum_reg    <= '0;
            clip_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            basis_reg   <= '0;
            act_cnt_reg <= '0;
            waddr_reg   <= '0;
            acc_e_reg   <= '0;
            acc_b_reg   <= '0;
            for (int j = 0; j < STATE_DIM; j++) begin
                digit_reg[j] <= '0;
            end
        end else begin
            // a new beat loaded in S_EMIT takes the place of the one leaving
            if (m_valid_reg && m_ready && state_reg != S_EMIT) begin
                m_valid_reg <= 1'b0;
            end
            v1_reg    <= issue_reg;
            last1_reg <= (basis_reg == BASIS_W'(NUM_BASIS - 1));
            a1_reg    <= act_cnt_reg;
            v2_reg    <= v1_reg;
            last2_reg <= last1_reg;
            a2_reg    <= a1_reg;
            if (v2_reg) begin
                if (last2_reg) begin
                    acc_e_reg <= '0;
                    acc_b_reg <= '0;
                end else begin
                    acc_e_reg <= sum_e;
                    acc_b_reg <= sum_b;
                end
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_kind) begin
                        state_reg <= S_PHI;
                        basis_reg <= '0;
                        for (int j = 0; j < STATE_DIM; j++) begin
                            digit_reg[j] <= '0;
                        end
                    end
                end
                S_PHI: begin
                    // mixed-radix digit counter, digit 0 least significant
                    begin
                        logic carry;
                        carry = 1'b1;
                        for (int j = 0; j < STATE_DIM; j++) begin
                            if (carry) begin
                                if (digit_reg[j] == DIGIT_W'(BASIS_ORDER)) begin
                                    digit_reg[j] <= '0;
                                end else begin
                                    digit_reg[j] <= digit_reg[j] + 1'b1;
                                    carry = 1'b0;
                                end
                            end
                        end
                    end
                    if (basis_reg == BASIS_W'(NUM_BASIS - 1)) begin
                        basis_reg   <= '0;
                        act_cnt_reg <= '0;
                        waddr_reg   <= '0;
                        issue_reg   <= 1'b1;
                        acc_e_reg   <= '0;
                        acc_b_reg   <= '0;
                        state_reg   <= S_DOT;
                    end else begin
                        basis_reg <= basis_reg + 1'b1;
                    end
                end
                S_DOT: begin
                    if (issue_reg) begin
                        waddr_reg <= waddr_reg + 1'b1;
                        if (basis_reg == BASIS_W'(NUM_BASIS - 1)) begin
                            basis_reg <= '0;
                            if (act_cnt_reg == ACT_W'(NUM_ACTIONS - 1)) begin
                                issue_reg <= 1'b0;
                            end else begin
                                act_cnt_reg <= act_cnt_reg + 1'b1;
                            end
                        end else begin
                            basis_reg <= basis_reg + 1'b1;
                        end
                    end
                    if (v2_reg && last2_reg && a2_reg == ACT_W'(NUM_ACTIONS - 1)) begin
                        state_reg   <= S_EXP;
                        exp_cnt_reg <= '0;
                        sub_reg     <= 1'b0;
                        se_reg      <= '0;
                        sb_reg      <= '0;
                    end
                end
                S_EXP: begin
                    sub_reg <= !sub_reg;
                    if (sub_reg) begin
                        se_reg <= se_reg + SUM_E_W'(ex_e);
                        sb_reg <= sb_reg + SUM_E_W'(ex_b);
                        if (exp_cnt_reg == act_reg) begin
                            ee_reg <= ex_e;
                            eb_reg <= ex_b;
                        end
                        if (exp_cnt_reg == ACT_W'(NUM_ACTIONS - 1)) begin
                            state_reg <= S_PREP;
                        end else begin
                            exp_cnt_reg <= exp_cnt_reg + 1'b1;
                        end
                    end
                end
                S_PREP: begin
                    if (eb_reg == '0) begin
                        q_reg     <= 32'hFFFF_FFFF;
                        clip_reg  <= 1'b1;
                        state_reg <= S_RATIO;
                    end else begin
                        quo_reg   <= {37'(ee_reg) * 37'(sb_reg), 16'd0};
                        den_reg   <= DEN_W'(37'(se_reg) * 37'(eb_reg));
                        rem_reg   <= '0;
                        dcnt_reg  <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (dcnt_reg == DCNT_W'(NUM_W)) begin
                        if (quo_reg[NUM_W-1:32] != '0) begin
                            q_reg    <= 32'hFFFF_FFFF;
                            clip_reg <= 1'b1;
                        end else begin
                            q_reg <= quo_reg[31:0];
                        end
                        state_reg <= S_RATIO;
                    end else begin
                        dcnt_reg <= dcnt_reg + 1'b1;
                        if (rem_s >= {1'b0, den_reg}) begin
                            rem_reg <= rem_s - {1'b0, den_reg};
                            quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
                        end else begin
                            rem_reg <= rem_s;
                            quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
                        end
                    end
                end
                S_RATIO: begin
                    if (rprod[63:48] != '0) begin
                        ratio_reg <= 32'hFFFF_FFFF;
                        clip_reg  <= 1'b1;
                    end else begin
                        ratio_reg <= rprod[47:16];
                    end
                    state_reg <= S_TERM;
                end
                S_TERM: begin
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    pdis_reg <= sat_p[47:0];
                    rsum_reg <= sat_r[47:0];
                    if (sat_p[48] || sat_r[48]) begin
                        clip_reg <= 1'b1;
                    end
                    state_reg <= last_reg ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_pdis_reg  <= pdis_reg;
                        m_rsum_reg  <= rsum_reg;
                        m_sat_reg   <= clip_reg;
                        ratio_reg   <= 32'h0001_0000;
                        pdis_reg    <= '0;
                        rsum_reg    <= '0;
                        clip_reg    <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pdis_estimate = m_pdis_reg;
    assign m_return_sum    = m_rsum_reg;
    assign m_saturated     = m_sat_reg;

endmodule
`default_nettype wire

>>> verif/tb_top.sv
module tb_top;
    import pdisfe_pkg::*;

    typedef struct packed {
        bit        kind;
        bit        pol;
        bit [5:0]  idx;
        bit [31:0] val;
        bit [15:0] f0;
        bit [15:0] f1;
        bit [15:0] f2;
        bit [15:0] f3;
        bit [1:0]  act;
        bit [31:0] rew;
        bit        last;
    } step_t;

    typedef struct packed {
        bit [47:0] pdis;
        bit [47:0] ret;
        bit        sat;
    } sums_t;

    typedef struct packed {
        step_t     it;
        bit        has_sums;
        sums_t     sums;
    } row_t;

    localparam bit KIND_WEIGHT = 1'b0;
    localparam bit KIND_STEP   = 1'b1;
    localparam bit POL_EVAL    = 1'b0;
    localparam bit POL_BEHAV   = 1'b1;
    localparam int STALL_LIMIT = 5000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_kind = 1'b0;
    logic        s_weight_policy = 1'b0;
    logic [5:0]  s_weight_index = '0;
    logic [31:0] s_weight_value = '0;
    logic [15:0] s_feature_0 = '0;
    logic [15:0] s_feature_1 = '0;
    logic [15:0] s_feature_2 = '0;
    logic [15:0] s_feature_3 = '0;
    logic [1:0]  s_action = '0;
    logic [31:0] s_reward = '0;
    logic        s_last_step = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [47:0] m_pdis_estimate;
    logic [47:0] m_return_sum;
    logic        m_saturated;

    pdis_softmax_fourier_estimator dut (.*);

    initial begin
        forever #4 aclk = ~aclk;
    end

    // fixed-point tables
    int unsigned cos_pts [17] = '{32768, 32610, 32138, 31357, 30274, 28899, 27246, 25330,
        23170, 20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};
    longint unsigned exp_int [12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8,
        3, 1};
    longint unsigned exp_frac [17] = '{65536, 61565, 57835, 54331, 51040, 47947, 45042,
        42313, 39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664, 24109};

    // predictor state
    bit [31:0] eval_w [64];
    bit [31:0] behav_w [64];
    bit [31:0] run_ratio = 32'h0001_0000;
    longint    pdis_run = 0;
    longint    reward_sum = 0;
    bit        clipped = 1'b0;

    sums_t owed_sums [$];
    int    fails = 0;
    int    episodes = 0;
    int    clip_episodes = 0;
    int    items = 0;
    bit    calm = 1'b0;

    function automatic int quarter_cos(int unsigned x);
        int unsigned i, fr;
        if (x >= 16384) return 0;
        i = x >> 10;
        fr = x & 1023;
        return int'(cos_pts[i] - (((cos_pts[i] - cos_pts[i + 1]) * fr) >> 10));
    endfunction

    function automatic int basis_cos(int unsigned p);
        int unsigned r;
        r = p & 16383;
        case ((p >> 14) & 3)
            0: return quarter_cos(r);
            1: return -quarter_cos(16384 - r);
            2: return -quarter_cos(r);
            default: return quarter_cos(16384 - r);
        endcase
    endfunction

    function automatic longint unsigned decay(longint unsigned u);
        longint unsigned n, f, j, fr, e;
        if (u >= (longint'(12) << 16)) return 0;
        n = u >> 16;
        f = u & 65535;
        j = f >> 12;
        fr = f & 4095;
        e = exp_frac[j] - (((exp_frac[j] - exp_frac[j + 1]) * fr) >> 12);
        return (exp_int[n] * e) >> 16;
    endfunction

    // softmax numerator of the taken action, denominator in den
    function automatic longint unsigned policy_odds(bit pol, int phi [NUM_BASIS],
                                                    int unsigned act,
                                                    output longint unsigned den);
        longint z [NUM_ACTIONS];
        longint zmax, acc;
        longint unsigned e, ea;
        bit [31:0] w;
        zmax = 0;
        ea = 0;
        den = 0;
        for (int a = 0; a < NUM_ACTIONS; a++) begin
            acc = 0;
            for (int i = 0; i < NUM_BASIS; i++) begin
                w = pol ? behav_w[(a * NUM_BASIS + i) & 63] : eval_w[(a * NUM_BASIS + i) & 63];
                acc += longint'($signed(w)) * phi[i];
            end
            z[a] = acc >>> 15;
            if (a == 0 || z[a] > zmax) zmax = z[a];
        end
        for (int a = 0; a < NUM_ACTIONS; a++) begin
            e = decay(64'(zmax - z[a]));
            den += e;
            if (a == act) ea = e;
        end
        return ea;
    endfunction

    function automatic longint clip_add(longint a, longint b);
        longint s;
        s = a + b;
        if (s > 64'sh7FFF_FFFF_FFFF) begin
            clipped = 1'b1;
            return 64'sh7FFF_FFFF_FFFF;
        end
        if (s < -64'sh8000_0000_0000) begin
            clipped = 1'b1;
            return -64'sh8000_0000_0000;
        end
        return s;
    endfunction

    task automatic estimate_step(step_t it);
        int phi [NUM_BASIS];
        int unsigned feat [4];
        int unsigned ph, rest, act;
        longint unsigned ee, eb, se, sb, q, r, mag, absr;
        longint rew, term;
        sums_t res;
        if (it.kind == KIND_WEIGHT) begin
            if (it.pol == POL_BEHAV) behav_w[it.idx] = it.val;
            else eval_w[it.idx] = it.val;
            return;
        end
        feat = '{32'(it.f0), 32'(it.f1), 32'(it.f2), 32'(it.f3)};
        for (int i = 0; i < NUM_BASIS; i++) begin
            ph = 0;
            rest = i;
            for (int j = 0; j < STATE_DIM; j++) begin
                ph += (rest % (BASIS_ORDER + 1)) * feat[j];
                rest = rest / (BASIS_ORDER + 1);
            end
            phi[i] = basis_cos(ph & 16'hFFFF);
        end
        act = 32'(it.act);
        if (act >= NUM_ACTIONS) act = NUM_ACTIONS - 1;
        ee = policy_odds(POL_EVAL, phi, act, se);
        eb = policy_odds(POL_BEHAV, phi, act, sb);
        if (eb == 0) begin
            q = 64'hFFFF_FFFF;
            clipped = 1'b1;
        end else begin
            q = ((ee * sb) << 16) / (se * eb);
            if (q > 64'hFFFF_FFFF) begin
                q = 64'hFFFF_FFFF;
                clipped = 1'b1;
            end
        end
        r = (64'(run_ratio) * q) >> 16;
        if (r > 64'hFFFF_FFFF) begin
            r = 64'hFFFF_FFFF;
            clipped = 1'b1;
        end
        run_ratio = r[31:0];
        rew = longint'($signed(it.rew));
        absr = rew < 0 ? -rew : rew;
        mag = (64'(run_ratio) * absr) >> 16;
        term = rew < 0 ? -longint'(mag) : longint'(mag);
        pdis_run = clip_add(pdis_run, term);
        reward_sum = clip_add(reward_sum, rew);
        if (!it.last) return;
        res.pdis = pdis_run[47:0];
        res.ret = reward_sum[47:0];
        res.sat = clipped;
        owed_sums.insert(owed_sums.size(), res);
        episodes++;
        if (clipped) clip_episodes++;
        run_ratio = 32'h0001_0000;
        pdis_run = 0;
        reward_sum = 0;
        clipped = 1'b0;
    endtask

    task automatic send(step_t it);
        while (!calm && $urandom_range(99) < 17) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= it.kind;
        s_weight_policy <= it.pol;
        s_weight_index <= it.idx;
        s_weight_value <= it.val;
        s_feature_0 <= it.f0;
        s_feature_1 <= it.f1;
        s_feature_2 <= it.f2;
        s_feature_3 <= it.f3;
        s_action <= it.act;
        s_reward <= it.rew;
        s_last_step <= it.last;
        do @(posedge aclk); while (!s_ready);
        estimate_step(it);
        items++;
    endtask

    function automatic step_t weight_beat(bit pol, bit [5:0] idx, bit [31:0] val);
        step_t it;
        it = '0;
        it.kind = KIND_WEIGHT;
        it.pol = pol;
        it.idx = idx;
        it.val = val;
        it.f0 = 16'($urandom);
        it.f1 = 16'($urandom);
        it.act = 2'($urandom);
        it.rew = $urandom;
        it.last = 1'($urandom);
        return it;
    endfunction

    function automatic step_t time_beat(bit [15:0] f0, bit [15:0] f1, bit [1:0] act,
                                        bit [31:0] rew, bit last);
        step_t it;
        it = '0;
        it.kind = KIND_STEP;
        it.f0 = f0;
        it.f1 = f1;
        it.f2 = 16'($urandom);
        it.f3 = 16'($urandom);
        it.act = act;
        it.rew = rew;
        it.last = last;
        it.pol = 1'($urandom);
        it.idx = 6'($urandom);
        it.val = $urandom;
        return it;
    endfunction

    function automatic row_t mk(step_t it, bit has, bit [47:0] p, bit [47:0] r, bit s);
        row_t rw;
        rw.it = it;
        rw.has_sums = has;
        rw.sums.pdis = p;
        rw.sums.ret = r;
        rw.sums.sat = s;
        return rw;
    endfunction

    function automatic bit [31:0] rand_weight();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70) return $urandom_range(131072) - 65536;
        if (sel < 85) return $urandom_range(1048576) - 524288;
        return $urandom;
    endfunction

    function automatic bit [15:0] rand_feature();
        return ($urandom_range(99) < 85) ? 16'($urandom_range(32768)) : 16'($urandom);
    endfunction

    function automatic bit [31:0] rand_reward();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60) return $urandom_range(1048576) - 524288;
        if (sel < 80) return $urandom_range(1 << 30) - (1 << 29);
        return $urandom;
    endfunction

    // result checker
    always @(posedge aclk) begin
        sums_t want;
        if (aresetn && m_valid && m_ready) begin
            if (owed_sums.size() == 0) begin
                $display("%0t: unexpected result beat pdis %h return %h sat %b", $time,
                         m_pdis_estimate, m_return_sum, m_saturated);
                fails++;
            end else begin
                want = owed_sums.pop_front();
                if (m_pdis_estimate !== want.pdis) begin
                    $display("%0t: pdis_estimate expected %h actual %h", $time, want.pdis,
                             m_pdis_estimate);
                    fails++;
                end
                if (m_return_sum !== want.ret) begin
                    $display("%0t: return_sum expected %h actual %h", $time, want.ret,
                             m_return_sum);
                    fails++;
                end
                if (m_saturated !== want.sat) begin
                    $display("%0t: saturated expected %b actual %b", $time, want.sat,
                             m_saturated);
                    fails++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 17);
    end

    int quiet = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet <= 0;
        end else if (quiet >= STALL_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
            $display("pdis_softmax_fourier_estimator regression: fail");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        row_t dir_tab [$];
        bit [31:0] v;
        int len;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // equal small tables: quotient is exactly one, pdis equals the plain sum
        for (int k = 0; k < 64; k++) begin
            v = $urandom_range(32768) - 16384;
            send(weight_beat(POL_EVAL, 6'(k), v));
            send(weight_beat(POL_BEHAV, 6'(k), v));
        end

        dir_tab.insert(dir_tab.size(), mk(time_beat(16'd0, 16'd0, 2'd0, 32'h7FFF_FFFF, 1'b1),
                       1'b1, 48'h0000_7FFF_FFFF, 48'h0000_7FFF_FFFF, 1'b0));
        dir_tab.insert(dir_tab.size(), mk(time_beat(16'd32768, 16'd32768, 2'd3,
                       32'h8000_0000, 1'b1), 1'b1, 48'hFFFF_8000_0000, 48'hFFFF_8000_0000,
                       1'b0));
        dir_tab.insert(dir_tab.size(), mk(time_beat(16'd16384, 16'd8192, 2'd1,
                       32'h0001_0000, 1'b0), 1'b0, '0, '0, 1'b0));
        dir_tab.insert(dir_tab.size(), mk(time_beat(16'd100, 16'd30000, 2'd2,
                       32'h0001_0000, 1'b1), 1'b1, 48'h0000_0002_0000, 48'h0000_0002_0000,
                       1'b0));
        dir_tab.insert(dir_tab.size(), mk(time_beat(16'hFFFF, 16'hFFFF, 2'd0, 32'd0, 1'b1),
                       1'b1, '0, '0, 1'b0));
        dir_tab.insert(dir_tab.size(), mk(time_beat(16'h8001, 16'h4000, 2'd2,
                       32'hFFFF_0000, 1'b0), 1'b0, '0, '0, 1'b0));
        // last_step on a weight beat is ignored
        dir_tab.insert(dir_tab.size(), mk(weight_beat(POL_EVAL, 6'd63, 32'h0000_4000),
                       1'b0, '0, '0, 1'b0));
        dir_tab.insert(dir_tab.size(), mk(time_beat(16'd12345, 16'd54321, 2'd1,
                       32'h0002_8000, 1'b1), 1'b0, '0, '0, 1'b0));
        // huge behavior score on action 0 starves the other actions
        dir_tab.insert(dir_tab.size(), mk(weight_beat(POL_BEHAV, 6'd0, 32'h7FFF_FFFF),
                       1'b0, '0, '0, 1'b0));
        dir_tab.insert(dir_tab.size(), mk(time_beat(16'd0, 16'd0, 2'd1, 32'h7FFF_FFFF, 1'b0),
                       1'b0, '0, '0, 1'b0));
        dir_tab.insert(dir_tab.size(), mk(time_beat(16'd0, 16'd0, 2'd1, 32'h7FFF_FFFF, 1'b0),
                       1'b0, '0, '0, 1'b0));
        dir_tab.insert(dir_tab.size(), mk(time_beat(16'd0, 16'd0, 2'd2, 32'h7FFF_FFFF, 1'b1),
                       1'b0, '0, '0, 1'b0));
        dir_tab.insert(dir_tab.size(), mk(time_beat(16'd0, 16'd0, 2'd3, 32'h8000_0000, 1'b0),
                       1'b0, '0, '0, 1'b0));
        dir_tab.insert(dir_tab.size(), mk(time_beat(16'd0, 16'd0, 2'd3, 32'h8000_0000, 1'b1),
                       1'b0, '0, '0, 1'b0));
        dir_tab.insert(dir_tab.size(), mk(weight_beat(POL_BEHAV, 6'd0, 32'h8000_0000),
                       1'b0, '0, '0, 1'b0));
        dir_tab.insert(dir_tab.size(), mk(weight_beat(POL_EVAL, 6'd16, 32'h7FFF_FFFF),
                       1'b0, '0, '0, 1'b0));
        dir_tab.insert(dir_tab.size(), mk(time_beat(16'd0, 16'd32768, 2'd0,
                       32'h0001_0000, 1'b0), 1'b0, '0, '0, 1'b0));
        dir_tab.insert(dir_tab.size(), mk(time_beat(16'd32768, 16'd0, 2'd1,
                       32'h0001_0000, 1'b1), 1'b0, '0, '0, 1'b0));

        foreach (dir_tab[n]) begin
            send(dir_tab[n].it);
            if (dir_tab[n].has_sums) begin
                void'(owed_sums.pop_back());
                owed_sums.insert(owed_sums.size(), dir_tab[n].sums);
            end
        end

        while (items < 1800) begin
            calm = (items >= 700 && items < 1000);
            if (items >= 1200 && items < 1210 && owed_sums.size() != 0) begin
                // hold off until the block has drained
                s_valid <= 1'b0;
                while (owed_sums.size() != 0) @(posedge aclk);
            end
            if ($urandom_range(99) < 12) begin
                len = $urandom_range(6, 1);
                repeat (len) send(weight_beat(1'($urandom), 6'($urandom), rand_weight()));
            end else begin
                len = $urandom_range(6, 1);
                for (int k = 1; k <= len; k++) begin
                    send(time_beat(rand_feature(), rand_feature(), 2'($urandom),
                                   rand_reward(), k == len));
                end
            end
        end
        s_valid <= 1'b0;
        calm = 1'b0;

        while (owed_sums.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);

        $display("covered %0d beats, %0d episodes closed, %0d of them clipped", items,
                 episodes, clip_episodes);
        $display("weight loads, extreme rewards, wrapped features and starved policies included");
        if (fails == 0) begin
            $display("pdis_softmax_fourier_estimator regression: pass");
        end else begin
            $display("pdis_softmax_fourier_estimator regression: fail");
        end
        $finish;
    end

endmodule
